// ----- design/rhv_pkg.sv -----
// Shared defaults for the RGB to HSV conversion pipeline.
package rhv_pkg;

	localparam int CHANNEL_BITS_DEF  = 8;
	localparam int FRACTION_BITS_DEF = 16;

	// Pipeline stages ahead of the long dividers.
	localparam int FRONT_STAGES = 2;

endpackage

// ----- design/rhv_front.sv -----
// Front stages: channel extremes, sector, hue numerator and the two division operands.
module rhv_front #(
	parameter int CHANNEL_BITS  = rhv_pkg::CHANNEL_BITS_DEF,
	parameter int FRACTION_BITS = rhv_pkg::FRACTION_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic [CHANNEL_BITS-1:0]               red_in,
	input  logic [CHANNEL_BITS-1:0]               green_in,
	input  logic [CHANNEL_BITS-1:0]               blue_in,
	output logic [CHANNEL_BITS-1:0]               val_s2,
	output logic [CHANNEL_BITS+2+FRACTION_BITS:0] hue_dvd_s2,
	output logic [CHANNEL_BITS+2:0]               hue_dsr_s2,
	output logic [CHANNEL_BITS+FRACTION_BITS-1:0] sat_dvd_s2,
	output logic [CHANNEL_BITS-1:0]               sat_dsr_s2
);

	localparam int C = CHANNEL_BITS;
	localparam int F = FRACTION_BITS;

	localparam logic [1:0] SECT_RED   = 2'd0;
	localparam logic [1:0] SECT_GREEN = 2'd1;
	localparam logic [1:0] SECT_BLUE  = 2'd2;

	logic         red_top;
	logic         green_top;
	logic [C-1:0] mx;
	logic [C-1:0] mn;
	logic [C-1:0] gb_min;
	logic [1:0]   sect;
	logic [C:0]   diff;

	logic [C-1:0] mx_s1;
	logic [C-1:0] mn_s1;
	logic [1:0]   sect_s1;
	logic [C:0]   diff_s1;

	logic [C-1:0] delta;
	logic [C+3:0] dlt_x;
	logic [C+3:0] span_x;
	logic [C+3:0] off_x;
	logic [C+3:0] num_raw;
	logic [C+3:0] num;

	always_comb begin
		red_top   = (red_in >= green_in) && (red_in >= blue_in);
		green_top = (green_in >= blue_in);
		gb_min    = (blue_in < green_in) ? blue_in : green_in;
		mn        = (gb_min < red_in) ? gb_min : red_in;
		if (red_top) begin
			mx   = red_in;
			sect = SECT_RED;
			diff = {1'b0, green_in} - {1'b0, blue_in};
		end else if (green_top) begin
			mx   = green_in;
			sect = SECT_GREEN;
			diff = {1'b0, blue_in} - {1'b0, red_in};
		end else begin
			mx   = blue_in;
			sect = SECT_BLUE;
			diff = {1'b0, red_in} - {1'b0, green_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1   <= mx;
			mn_s1   <= mn;
			sect_s1 <= sect;
			diff_s1 <= diff;
		end
	end

	always_comb begin
		delta  = mx_s1 - mn_s1;
		dlt_x  = {4'b0000, delta};
		span_x = (dlt_x << 2) + (dlt_x << 1);
		case (sect_s1)
			SECT_RED:   off_x = '0;
			SECT_GREEN: off_x = dlt_x << 1;
			SECT_BLUE:  off_x = dlt_x << 2;
			default:    off_x = '0;
		endcase
		num_raw = off_x + {{3{diff_s1[C]}}, diff_s1};
		num     = num_raw[C+3] ? (num_raw + span_x) : num_raw;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s2     <= mx_s1;
			hue_dvd_s2 <= {num[C+2:0], {F{1'b0}}};
			hue_dsr_s2 <= (delta == '0) ? (C+3)'(1) : span_x[C+2:0];
			sat_dvd_s2 <= {delta, {F{1'b0}}} - {{F{1'b0}}, delta};
			sat_dsr_s2 <= (mx_s1 == '0) ? C'(1) : mx_s1;
		end
	end

endmodule

// ----- design/rhv_divider.sv -----
// Pipelined restoring divider that settles one quotient bit per stage.
module rhv_divider #(
	parameter int DSR_BITS = rhv_pkg::CHANNEL_BITS_DEF,
	parameter int QUO_BITS = rhv_pkg::FRACTION_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [DSR_BITS+QUO_BITS-1:0] dividend,
	input  logic [DSR_BITS-1:0]          divisor,
	output logic [QUO_BITS-1:0]          quotient
);

	localparam int D = DSR_BITS;
	localparam int Q = QUO_BITS;

	logic [D-1:0] rem_s [Q];
	logic [D-1:0] dsr_s [Q];
	logic [Q-1:0] low_s [Q];
	logic [Q-1:0] quo_s [Q];

	for (genvar i = 0; i < Q; i++) begin : g_stage
		logic [D-1:0] src_rem;
		logic [D-1:0] src_dsr;
		logic [Q-1:0] src_low;
		logic [Q-1:0] src_quo;
		logic [D:0]   trial;
		logic [D:0]   diff;
		logic         ge;

		if (i == 0) begin : g_first
			assign src_rem = dividend[D+Q-1:Q];
			assign src_dsr = divisor;
			assign src_low = dividend[Q-1:0];
			assign src_quo = '0;
		end else begin : g_next
			assign src_rem = rem_s[i-1];
			assign src_dsr = dsr_s[i-1];
			assign src_low = low_s[i-1];
			assign src_quo = quo_s[i-1];
		end

		assign trial = {src_rem, src_low[Q-1]};
		assign ge    = trial >= {1'b0, src_dsr};
		assign diff  = trial - {1'b0, src_dsr};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? diff[D-1:0] : trial[D-1:0];
				dsr_s[i] <= src_dsr;
				low_s[i] <= {src_low[Q-2:0], 1'b0};
				quo_s[i] <= {src_quo[Q-2:0], ge};
			end
		end
	end

	assign quotient = quo_s[Q-1];

endmodule

// ----- design/rgb_to_hsv_converter_top.sv -----
// Top level of the RGB to HSV converter: pipeline control, value delay line and output skid.
//
// Pixels arrive on the pix channel (pix_valid, pix_ready, red_in, green_in, blue_in)
// and results leave on the hsv channel (hsv_valid, hsv_ready, hue_out, sat_out, val_out).
// Each item gives exactly one result, in order.
// The pipeline has FRACTION_BITS + 2 register stages: two front stages find the
// extremes and form the operands, then two long dividers, one for hue and one for
// saturation, settle one quotient bit per stage.
// hsv_valid comes from the valid bit of the last stage, so an item's result is offered
// once the item has passed through every register stage.
// Throughput is one item per cycle while the receiver does not stall, set by the one-bit-per-stage divider pipelines.
// Reset clears every stage valid bit and the skid full flag; no item is in flight
// afterwards and pix_ready is high.
// When the receiver stalls, the pipeline moves once more and the oldest result
// is parked in the skid register; from then on pix_ready is low and the whole
// pipeline holds until the skid item is taken. No item is lost or repeated.
module rgb_to_hsv_converter_top #(
	parameter int CHANNEL_BITS  = rhv_pkg::CHANNEL_BITS_DEF,
	parameter int FRACTION_BITS = rhv_pkg::FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     pix_valid,
	output logic                     pix_ready,
	input  logic [CHANNEL_BITS-1:0]  red_in,
	input  logic [CHANNEL_BITS-1:0]  green_in,
	input  logic [CHANNEL_BITS-1:0]  blue_in,
	output logic                     hsv_valid,
	input  logic                     hsv_ready,
	output logic [FRACTION_BITS-1:0] hue_out,
	output logic [FRACTION_BITS-1:0] sat_out,
	output logic [CHANNEL_BITS-1:0]  val_out
);

	localparam int C  = CHANNEL_BITS;
	localparam int F  = FRACTION_BITS;
	localparam int NS = rhv_pkg::FRONT_STAGES + F;

	logic          pen;
	logic [NS-1:0] vld_q;
	logic          last_vld;
	logic          skid_full_q;

	logic [C-1:0]     val_s2;
	logic [C+2+F:0]   hue_dvd_s2;
	logic [C+2:0]     hue_dsr_s2;
	logic [C+F-1:0]   sat_dvd_s2;
	logic [C-1:0]     sat_dsr_s2;
	logic [F-1:0]     hue_q;
	logic [F-1:0]     sat_q;
	logic [C-1:0]     val_s [F];

	logic [F-1:0] skid_hue_q;
	logic [F-1:0] skid_sat_q;
	logic [C-1:0] skid_val_q;

	assign pen       = !skid_full_q;
	assign pix_ready = pen;
	assign last_vld  = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pen) begin
			vld_q <= {vld_q[NS-2:0], pix_valid};
		end
	end

	rhv_front #(
		.CHANNEL_BITS  (C),
		.FRACTION_BITS (F)
	) u_front (
		.clk        (clk),
		.en         (pen),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.val_s2     (val_s2),
		.hue_dvd_s2 (hue_dvd_s2),
		.hue_dsr_s2 (hue_dsr_s2),
		.sat_dvd_s2 (sat_dvd_s2),
		.sat_dsr_s2 (sat_dsr_s2)
	);

	rhv_divider #(
		.DSR_BITS (C + 3),
		.QUO_BITS (F)
	) u_hue_div (
		.clk      (clk),
		.en       (pen),
		.dividend (hue_dvd_s2),
		.divisor  (hue_dsr_s2),
		.quotient (hue_q)
	);

	rhv_divider #(
		.DSR_BITS (C),
		.QUO_BITS (F)
	) u_sat_div (
		.clk      (clk),
		.en       (pen),
		.dividend (sat_dvd_s2),
		.divisor  (sat_dsr_s2),
		.quotient (sat_q)
	);

	always_ff @(posedge clk) begin
		if (pen) begin
			val_s[0] <= val_s2;
		end
	end

	for (genvar i = 1; i < F; i++) begin : g_val
		always_ff @(posedge clk) begin
			if (pen) begin
				val_s[i] <= val_s[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			skid_full_q <= !hsv_ready;
		end else begin
			skid_full_q <= last_vld && !hsv_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			skid_hue_q <= hue_q;
			skid_sat_q <= sat_q;
			skid_val_q <= val_s[F-1];
		end
	end

	assign hsv_valid = skid_full_q || last_vld;
	assign hue_out   = skid_full_q ? skid_hue_q : hue_q;
	assign sat_out   = skid_full_q ? skid_sat_q : sat_q;
	assign val_out   = skid_full_q ? skid_val_q : val_s[F-1];

	a_black_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && (val_out == '0) |-> (sat_out == '0) && (hue_out == '0))
		else $error("Black pixel gave non-zero saturation or hue.");

	a_stall_parks: assert property (@(posedge clk) disable iff (!arst_n)
		last_vld && !hsv_ready && !skid_full_q |=> skid_full_q && hsv_valid)
		else $error("Stalled item was not parked in the skid register.");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && !hsv_ready |=> skid_full_q && $stable(skid_hue_q)
			&& $stable(skid_sat_q) && $stable(skid_val_q) && $stable(vld_q))
		else $error("Skid item or pipeline moved during a stall.");

endmodule

// ----- verif/hsv_result_checker.sv -----
`timescale 1ns / 100ps
// Checker for the RGB to HSV converter: predicts each pixel's hue, saturation and value.
module hsv_result_checker #(
	parameter int CHANNEL_BITS  = rhv_pkg::CHANNEL_BITS_DEF,
	parameter int FRACTION_BITS = rhv_pkg::FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     pix_valid,
	input  logic                     pix_ready,
	input  logic [CHANNEL_BITS-1:0]  red_in,
	input  logic [CHANNEL_BITS-1:0]  green_in,
	input  logic [CHANNEL_BITS-1:0]  blue_in,
	input  logic                     hsv_valid,
	input  logic                     hsv_ready,
	input  logic [FRACTION_BITS-1:0] hue_out,
	input  logic [FRACTION_BITS-1:0] sat_out,
	input  logic [CHANNEL_BITS-1:0]  val_out,
	output int                       fail_count,
	output int                       pending
);

	typedef struct packed {
		logic [FRACTION_BITS-1:0] hue;
		logic [FRACTION_BITS-1:0] sat;
		logic [CHANNEL_BITS-1:0]  val;
	} hsv_t;

	hsv_t pending_hsv[$];

	function automatic hsv_t convert_pixel(logic [CHANNEL_BITS-1:0] r_ch,
			logic [CHANNEL_BITS-1:0] g_ch, logic [CHANNEL_BITS-1:0] b_ch);
		longint r, g, b, peak, floor_ch, delta, num, span;
		hsv_t res;
		r = longint'(r_ch);
		g = longint'(g_ch);
		b = longint'(b_ch);
		peak = r;
		if (g > peak) peak = g;
		if (b > peak) peak = b;
		floor_ch = r;
		if (g < floor_ch) floor_ch = g;
		if (b < floor_ch) floor_ch = b;
		delta = peak - floor_ch;
		res.val = CHANNEL_BITS'(peak);
		res.sat = '0;
		res.hue = '0;
		if (peak != 0)
			res.sat = FRACTION_BITS'((delta * ((longint'(1) << FRACTION_BITS) - 1)) / peak);
		if (delta != 0) begin
			span = 6 * delta;
			if (peak == r)
				num = g - b;
			else if (peak == g)
				num = 2 * delta + (b - r);
			else
				num = 4 * delta + (r - g);
			if (num < 0)
				num = num + span;
			res.hue = FRACTION_BITS'((num << FRACTION_BITS) / span);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hsv_t want;
		if (!arst_n) begin
			fail_count = 0;
			pending = 0;
			pending_hsv.delete();
		end else begin
			if (pix_valid && pix_ready)
				pending_hsv.push_back(convert_pixel(red_in, green_in, blue_in));
			if (hsv_valid && hsv_ready) begin
				if (pending_hsv.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual hue %h sat %h val %h",
						$time, hue_out, sat_out, val_out);
					fail_count++;
				end else begin
					want = pending_hsv.pop_front();
					if (hue_out !== want.hue) begin
						$display("%0t: hue_out mismatch, expected %h, actual %h",
							$time, want.hue, hue_out);
						fail_count++;
					end
					if (sat_out !== want.sat) begin
						$display("%0t: sat_out mismatch, expected %h, actual %h",
							$time, want.sat, sat_out);
						fail_count++;
					end
					if (val_out !== want.val) begin
						$display("%0t: val_out mismatch, expected %h, actual %h",
							$time, want.val, val_out);
						fail_count++;
					end
				end
			end
			pending = pending_hsv.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the RGB to HSV converter: pixel stimulus, result stalls and verdict.
module tb;

	localparam int CB            = rhv_pkg::CHANNEL_BITS_DEF;
	localparam int FB            = rhv_pkg::FRACTION_BITS_DEF;
	localparam int RANDOM_PIXELS = 500;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = FB + 2 + 30;
	localparam int HOLD_CYCLES   = 80;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          pix_valid = 1'b0;
	logic          hsv_ready = 1'b0;
	logic [CB-1:0] red_in    = '0;
	logic [CB-1:0] green_in  = '0;
	logic [CB-1:0] blue_in   = '0;
	logic          pix_ready;
	logic          hsv_valid;
	logic [FB-1:0] hue_out;
	logic [FB-1:0] sat_out;
	logic [CB-1:0] val_out;

	bit idle_en   = 1'b1;
	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;
	int cycle_count = 0;
	int fail_count;
	int pending;

	rgb_to_hsv_converter_top #(
		.CHANNEL_BITS (CB),
		.FRACTION_BITS(FB)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.hsv_valid(hsv_valid),
		.hsv_ready(hsv_ready),
		.hue_out  (hue_out),
		.sat_out  (sat_out),
		.val_out  (val_out)
	);

	hsv_result_checker #(
		.CHANNEL_BITS (CB),
		.FRACTION_BITS(FB)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hue_out   (hue_out),
		.sat_out   (sat_out),
		.val_out   (val_out),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// The receiver stalls at random while idle_en is set, and once holds off long enough for the pipeline to fill.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hsv_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hsv_ready <= 1'b1;
			end else begin
				hsv_ready <= !idle_en || ($urandom_range(0, 99) >= 24);
			end
		end
	end

	task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
			input logic [CB-1:0] b);
		int gap;
		gap = 0;
		while (idle_en && $urandom_range(0, 99) < 24)
			gap++;
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		red_in    <= r;
		green_in  <= g;
		blue_in   <= b;
		do @(posedge clk); while (!pix_ready);
	endtask

	initial begin
		int peak, low, base, pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd200, 8'd10, 8'd150);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd1, 8'd1, 8'd0);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd254, 8'd255, 8'd253);
		send_pixel(8'd170, 8'd85, 8'd255);
		send_pixel(8'd85, 8'd170, 8'd0);
		send_pixel(8'd1, 8'd1, 8'd1);
		send_pixel(8'd170, 8'd170, 8'd85);

		for (int n = 0; n < RANDOM_PIXELS; n++) begin
			idle_en = !(n >= 250 && n < 350);
			if (n == 100)
				hold_req = 1'b1;
			pick = $urandom_range(0, 9);
			case (pick)
				0: begin
					base = $urandom_range(0, 255);
					send_pixel(CB'(base), CB'(base), CB'(base));
				end
				1, 2: begin
					peak = $urandom_range(1, 255);
					low  = $urandom_range(0, peak);
					case ($urandom_range(0, 2))
						0: send_pixel(CB'(peak), CB'(peak), CB'(low));
						1: send_pixel(CB'(peak), CB'(low), CB'(peak));
						default: send_pixel(CB'(low), CB'(peak), CB'(peak));
					endcase
				end
				3, 4: begin
					base = $urandom_range(0, 250);
					send_pixel(CB'(base + $urandom_range(0, 5)), CB'(base + $urandom_range(0, 5)),
						CB'(base + $urandom_range(0, 5)));
				end
				default: begin
					send_pixel(CB'($urandom_range(0, 255)), CB'($urandom_range(0, 255)),
						CB'($urandom_range(0, 255)));
				end
			endcase
		end
		pix_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
